[src/limit_order_book_matcher_core_defines.svh]
// assertion macros shared by the order book matcher
`ifndef LIMIT_ORDER_BOOK_MATCHER_CORE_DEFINES_SVH
`define LIMIT_ORDER_BOOK_MATCHER_CORE_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define LOBM_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LOBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/lobm_pkg.sv]
// package: types, constants and arithmetic helpers for the order book matcher
package lobm_pkg;

  localparam int FIELD_W = 30;
  localparam logic [FIELD_W-1:0] BACKLOG_MOD = 30'd1000000007;

  typedef logic [2*FIELD_W-1:0] key_t;
  typedef logic [FIELD_W-1:0]   field_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_M_CHECK,
    S_M_TOP,
    S_SUB,
    S_M_LAST,
    S_DN_L,
    S_DN_R,
    S_DN_C,
    S_REST,
    S_ADD,
    S_UP,
    S_UP_C,
    S_DONE
  } state_t;

  function automatic field_t mod_reduce(input field_t a);
    return (a >= BACKLOG_MOD) ? a - BACKLOG_MOD : a;
  endfunction

  function automatic field_t mod_add(input field_t t, input field_t a);
    logic [FIELD_W:0] s;
    s = {1'b0, t} + {1'b0, mod_reduce(a)};
    return (s >= {1'b0, BACKLOG_MOD}) ? field_t'(s - {1'b0, BACKLOG_MOD}) : field_t'(s);
  endfunction

  function automatic field_t mod_sub(input field_t t, input field_t a);
    field_t r;
    r = mod_reduce(a);
    return (t >= r) ? t - r : t + (BACKLOG_MOD - r);
  endfunction

  // strict ranking: larger key first in a max-heap, smaller in a min-heap
  function automatic logic ranks_above(input key_t a, input key_t b, input logic is_max);
    return is_max ? (a > b) : (a < b);
  endfunction

endpackage

[src/lobm_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
module lobm_ram #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[src/limit_order_book_matcher_core.sv]
// Limit order book matcher: one order word in, one backlog word out. Resting buys
// sit in a max-heap and resting sells in a min-heap, each in its own RAM with a
// registered read; every heap step is a read followed by a write-back through the
// shared index register. An order is matched against the top of the opposite heap;
// each top entry it consumes or shrinks is followed by a sift-down, and a resting
// remainder by a sift-up, so the heap depth and the single RAM port pair set how
// long an order takes. A new order is taken only once the previous one is finished,
// while the previous result may still be waiting.
`include "limit_order_book_matcher_core_defines.svh"

module limit_order_book_matcher_core #(
  parameter int BOOK_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lobm_pkg::field_t     in_order_price,
  input  lobm_pkg::field_t     in_order_amount,
  input  logic                 in_order_side,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lobm_pkg::field_t     out_backlog_total,
  output logic                 out_book_full
);

  import lobm_pkg::*;

  localparam int AW = $clog2(BOOK_DEPTH);
  localparam int CW = $clog2(BOOK_DEPTH + 1);

  state_t          state_r, state_nxt;
  logic            side_r, side_nxt;
  field_t          price_r, price_nxt;
  field_t          amt_r, amt_nxt;
  logic            full_r, full_nxt;
  logic            book_sel_r, book_sel_nxt;
  logic            pop_r, pop_nxt;
  logic            has_r_r, has_r_nxt;
  logic [CW-1:0]   buy_cnt_r, buy_cnt_nxt;
  logic [CW-1:0]   sell_cnt_r, sell_cnt_nxt;
  field_t          total_r, total_nxt;
  key_t            key_r, key_nxt;
  key_t            hl_r, hl_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  field_t          sub_r, sub_nxt;
  logic            out_valid_r, out_valid_nxt;
  field_t          out_total_r, out_total_nxt;
  logic            out_full_r, out_full_nxt;

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  key_t            wr_data;
  logic [AW-1:0]   rd_addr;
  key_t            buy_rdata, sell_rdata, rdata;

  logic [CW-1:0]   cur_cnt, own_cnt;
  logic [CW:0]     cnt_ext, lchild, rchild;
  logic [CW-1:0]   parent;
  field_t          top_price, top_amt;
  logic            crosses, top_fills, is_max;
  logic            take_l, take_r;
  key_t            best_l;
  logic            in_accept, out_free;

  lobm_ram #(.WIDTH(2*FIELD_W), .DEPTH(BOOK_DEPTH)) u_buy_ram (
    .clk     (clk),
    .wr_en   (wr_en && !book_sel_r),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (buy_rdata)
  );

  lobm_ram #(.WIDTH(2*FIELD_W), .DEPTH(BOOK_DEPTH)) u_sell_ram (
    .clk     (clk),
    .wr_en   (wr_en && book_sel_r),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (sell_rdata)
  );

  assign rdata     = book_sel_r ? sell_rdata : buy_rdata;
  assign is_max    = !book_sel_r;
  assign cur_cnt   = book_sel_r ? sell_cnt_r : buy_cnt_r;
  assign own_cnt   = side_r ? sell_cnt_r : buy_cnt_r;
  assign cnt_ext   = {1'b0, cur_cnt};
  assign lchild    = {idx_r, 1'b1};
  assign rchild    = lchild + (CW+1)'(1);
  assign parent    = (idx_r - CW'(1)) >> 1;
  assign top_price = rdata[2*FIELD_W-1:FIELD_W];
  assign top_amt   = rdata[FIELD_W-1:0];
  assign crosses   = side_r ? (top_price >= price_r) : (top_price <= price_r);
  assign top_fills = top_amt <= amt_r;
  assign take_l    = ranks_above(hl_r, key_r, is_max);
  assign best_l    = take_l ? hl_r : key_r;
  assign take_r    = has_r_r && ranks_above(rdata, best_l, is_max);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_backlog_total = out_total_r;
  assign out_book_full     = out_full_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_accept) state_nxt = S_M_CHECK;
      S_M_CHECK: state_nxt = (amt_r == '0 || cur_cnt == '0) ? S_REST : S_M_TOP;
      S_M_TOP:   state_nxt = crosses ? S_SUB : S_REST;
      S_SUB: begin
        if (!pop_r) state_nxt = S_DN_L;
        else if (cur_cnt == '0) state_nxt = S_M_CHECK;
        else state_nxt = S_M_LAST;
      end
      S_M_LAST:  state_nxt = S_DN_L;
      S_DN_L:    state_nxt = (lchild >= cnt_ext) ? S_M_CHECK : S_DN_R;
      S_DN_R:    state_nxt = S_DN_C;
      S_DN_C:    state_nxt = (take_l || take_r) ? S_DN_L : S_M_CHECK;
      S_REST: begin
        if (amt_r == '0 || own_cnt == CW'(BOOK_DEPTH)) state_nxt = S_DONE;
        else state_nxt = S_ADD;
      end
      S_ADD:     state_nxt = S_UP;
      S_UP:      state_nxt = (idx_r == '0) ? S_DONE : S_UP_C;
      S_UP_C:    state_nxt = ranks_above(key_r, rdata, is_max) ? S_UP : S_DONE;
      S_DONE:    if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    side_nxt      = side_r;
    price_nxt     = price_r;
    amt_nxt       = amt_r;
    full_nxt      = full_r;
    book_sel_nxt  = book_sel_r;
    pop_nxt       = pop_r;
    has_r_nxt     = has_r_r;
    buy_cnt_nxt   = buy_cnt_r;
    sell_cnt_nxt  = sell_cnt_r;
    total_nxt     = total_r;
    key_nxt       = key_r;
    hl_nxt        = hl_r;
    idx_nxt       = idx_r;
    sub_nxt       = sub_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_total_nxt = out_total_r;
    out_full_nxt  = out_full_r;
    wr_en         = 1'b0;
    wr_addr       = idx_r[AW-1:0];
    wr_data       = key_r;
    rd_addr       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          side_nxt     = in_order_side;
          price_nxt    = in_order_price;
          amt_nxt      = in_order_amount;
          full_nxt     = 1'b0;
          book_sel_nxt = !in_order_side;
        end
      end
      S_M_CHECK: rd_addr = '0;
      S_M_TOP: begin
        if (crosses) begin
          pop_nxt = top_fills;
          idx_nxt = '0;
          if (top_fills) begin
            sub_nxt = top_amt;
            amt_nxt = amt_r - top_amt;
            if (book_sel_r) sell_cnt_nxt = sell_cnt_r - CW'(1);
            else buy_cnt_nxt = buy_cnt_r - CW'(1);
          end else begin
            // partial fill: shrink the top entry in place
            sub_nxt = amt_r;
            amt_nxt = '0;
            key_nxt = {top_price, top_amt - amt_r};
          end
        end
      end
      S_SUB: begin
        total_nxt = mod_sub(total_r, sub_r);
        rd_addr   = cur_cnt[AW-1:0];
      end
      S_M_LAST: begin
        key_nxt = rdata;
        idx_nxt = '0;
      end
      S_DN_L: begin
        if (lchild >= cnt_ext) begin
          wr_en = 1'b1;
        end else begin
          rd_addr = lchild[AW-1:0];
        end
      end
      S_DN_R: begin
        hl_nxt    = rdata;
        has_r_nxt = rchild < cnt_ext;
        rd_addr   = rchild[AW-1:0];
      end
      S_DN_C: begin
        wr_en = 1'b1;
        if (take_r) begin
          wr_data = rdata;
          idx_nxt = rchild[CW-1:0];
        end else if (take_l) begin
          wr_data = hl_r;
          idx_nxt = lchild[CW-1:0];
        end
      end
      S_REST: begin
        book_sel_nxt = side_r;
        if (amt_r != '0) begin
          if (own_cnt == CW'(BOOK_DEPTH)) begin
            full_nxt = 1'b1;
          end else begin
            key_nxt = {price_r, amt_r};
            idx_nxt = own_cnt;
            sub_nxt = amt_r;
            if (side_r) sell_cnt_nxt = sell_cnt_r + CW'(1);
            else buy_cnt_nxt = buy_cnt_r + CW'(1);
          end
        end
      end
      S_ADD: total_nxt = mod_add(total_r, sub_r);
      S_UP: begin
        if (idx_r == '0) begin
          wr_en = 1'b1;
        end else begin
          rd_addr = parent[AW-1:0];
        end
      end
      S_UP_C: begin
        wr_en = 1'b1;
        if (ranks_above(key_r, rdata, is_max)) begin
          wr_data = rdata;
          idx_nxt = parent;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_total_nxt = total_r;
          out_full_nxt  = full_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      buy_cnt_r   <= '0;
      sell_cnt_r  <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      buy_cnt_r   <= buy_cnt_nxt;
      sell_cnt_r  <= sell_cnt_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
    side_r      <= side_nxt;
    price_r     <= price_nxt;
    amt_r       <= amt_nxt;
    full_r      <= full_nxt;
    book_sel_r  <= book_sel_nxt;
    pop_r       <= pop_nxt;
    has_r_r     <= has_r_nxt;
    key_r       <= key_nxt;
    hl_r        <= hl_nxt;
    idx_r       <= idx_nxt;
    sub_r       <= sub_nxt;
    out_total_r <= out_total_nxt;
    out_full_r  <= out_full_nxt;
  end

  `LOBM_ASSERT_ALWAYS(a_buy_cnt_range, buy_cnt_r <= CW'(BOOK_DEPTH), "buy count past depth")
  `LOBM_ASSERT_ALWAYS(a_sell_cnt_range, sell_cnt_r <= CW'(BOOK_DEPTH), "sell count past depth")
  `LOBM_ASSERT_ALWAYS(a_total_range, total_r < BACKLOG_MOD, "backlog total not reduced")
  `LOBM_ASSERT_NEXT(a_accept_starts, in_accept, state_r == S_M_CHECK, "accepted word not started")

endmodule
